### rtl/core/i8gemv_pkg.sv
// shared types and constants of the int8 weight batched gemv unit
// no dependencies
package i8gemv_pkg;

	localparam int LANES   = 4;
	localparam int W_W     = 8;
	localparam int ACT_W   = 16;
	localparam int PROD_W  = W_W + ACT_W;
	localparam int ACC_W   = 40;
	localparam int SCALE_W = 32;
	localparam int HALF_W  = SCALE_W / 2;
	localparam int PP_W    = ACC_W + HALF_W;
	localparam int SUM_W   = PP_W + HALF_W;
	localparam int FRAC_SH = 24;
	localparam int Q_W     = SUM_W - FRAC_SH;
	localparam int OUT_W   = 32;
	localparam int BR_W    = 3;

	localparam logic [BR_W-1:0]  BATCH_RESET = BR_W'(4);
	localparam logic [SUM_W-1:0] ROUND_HALF  = SUM_W'(1) << (FRAC_SH - 1);
	localparam logic [Q_W-1:0]   POS_LIMIT   = Q_W'(32'h7fff_ffff);
	localparam logic [Q_W-1:0]   NEG_LIMIT   = Q_W'(32'h8000_0000);
	localparam logic [OUT_W-1:0] OUT_POS_MAX = 32'h7fff_ffff;
	localparam logic [OUT_W-1:0] OUT_NEG_MIN = 32'h8000_0000;

	typedef struct packed {
		logic acc_en;
		logic mag_en;
		logic hi_en;
		logic lo_en;
		logic sum_en;
	} lane_ctl_t;

endpackage

### rtl/core/int8_weight_batched_gemv_unit.sv
// int8 weight batched gemv unit: four lanes share each weight and accumulate
// items without end_of_row are taken back to back; an end_of_row item stops input
// for the per-lane sequence magnitude, two 40x16 partial products, sum, clip
// the result word is registered once the clip state finds the output free
// async active-low reset clears accumulators, output valid, batch_rows to 4
module int8_weight_batched_gemv_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         batch_rows,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [7:0]  weight,
	input  logic signed [15:0] act_lane0,
	input  logic signed [15:0] act_lane1,
	input  logic signed [15:0] act_lane2,
	input  logic signed [15:0] act_lane3,
	input  logic [31:0]        row_scale,
	input  logic               end_of_row,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_lane0,
	output logic signed [31:0] out_lane1,
	output logic signed [31:0] out_lane2,
	output logic signed [31:0] out_lane3,
	output logic               saturated
);
	import i8gemv_pkg::*;

	localparam logic [2:0] S_ACC = 3'd0;
	localparam logic [2:0] S_MAG = 3'd1;
	localparam logic [2:0] S_HI  = 3'd2;
	localparam logic [2:0] S_LO  = 3'd3;
	localparam logic [2:0] S_SUM = 3'd4;
	localparam logic [2:0] S_SAT = 3'd5;

	logic [2:0]                       state_q;
	logic [BR_W-1:0]                  batch_q;
	logic [SCALE_W-1:0]               scale_q;
	logic                             accept;
	logic                             free;
	logic                             load;
	lane_ctl_t                        ctl;
	logic signed [ACT_W-1:0]          act_w [LANES];
	logic [LANES-1:0][OUT_W-1:0]      lane_res;
	logic [LANES-1:0]                 lane_sat;
	logic [LANES-1:0][OUT_W-1:0]      res_w;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_ACC);
	assign accept    = in_valid && in_ready;
	assign load      = (state_q == S_SAT) && free;

	assign ctl.acc_en = accept;
	assign ctl.mag_en = (state_q == S_MAG);
	assign ctl.hi_en  = (state_q == S_HI);
	assign ctl.lo_en  = (state_q == S_LO);
	assign ctl.sum_en = (state_q == S_SUM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_q <= BATCH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			batch_q <= batch_rows;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
		end else begin
			case (state_q)
				S_ACC: begin
					if (accept && end_of_row) begin
						state_q <= S_MAG;
					end
				end
				S_MAG: state_q <= S_HI;
				S_HI:  state_q <= S_LO;
				S_LO:  state_q <= S_SUM;
				S_SUM: state_q <= S_SAT;
				S_SAT: begin
					if (free) begin
						state_q <= S_ACC;
					end
				end
				default: state_q <= S_ACC;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && end_of_row) begin
			scale_q <= row_scale;
		end
	end

	assign act_w[0] = act_lane0;
	assign act_w[1] = act_lane1;
	assign act_w[2] = act_lane2;
	assign act_w[3] = act_lane3;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		i8gemv_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.active (batch_q > BR_W'(i)),
			.weight (weight),
			.act    (act_w[i]),
			.scale  (scale_q),
			.res    (lane_res[i]),
			.sat    (lane_sat[i])
		);
	end

	i8gemv_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.lane_res  (lane_res),
		.lane_sat  (lane_sat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (free),
		.res_q     (res_w),
		.sat_q     (saturated)
	);

	assign out_lane0 = res_w[0];
	assign out_lane1 = res_w[1];
	assign out_lane2 = res_w[2];
	assign out_lane3 = res_w[3];

`ifndef SYNTH
	a_eor_starts_scaling: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_row |=> state_q == S_MAG && !in_ready)
		else $error("end of row word did not start scaling");

	a_result_from_clip_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_SAT)
		else $error("result word appeared outside the clip stage");

	a_sat_means_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			out_lane0 == OUT_POS_MAX || out_lane0 == OUT_NEG_MIN ||
			out_lane1 == OUT_POS_MAX || out_lane1 == OUT_NEG_MIN ||
			out_lane2 == OUT_POS_MAX || out_lane2 == OUT_NEG_MIN ||
			out_lane3 == OUT_POS_MAX || out_lane3 == OUT_NEG_MIN)
		else $error("saturated flag without a clipped lane");
`endif

endmodule

### rtl/core/i8gemv_lane.sv
// one batch lane: multiply-accumulate, then scale by the row scale and round
// uses i8gemv_pkg
module i8gemv_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i8gemv_pkg::lane_ctl_t         ctl,
	input  logic                          active,
	input  logic signed [i8gemv_pkg::W_W-1:0]     weight,
	input  logic signed [i8gemv_pkg::ACT_W-1:0]   act,
	input  logic [i8gemv_pkg::SCALE_W-1:0]        scale,
	output logic [i8gemv_pkg::OUT_W-1:0]          res,
	output logic                          sat
);
	import i8gemv_pkg::*;

	logic signed [PROD_W-1:0] prod_w;
	logic [ACC_W-1:0]         acc_q;
	logic [ACC_W-1:0]         mag_q;
	logic                     neg_q;
	logic [HALF_W-1:0]        mul_b;
	logic [PP_W-1:0]          mul_p;
	logic [PP_W-1:0]          p_hi_q;
	logic [PP_W-1:0]          p_lo_q;
	logic [SUM_W-1:0]         sum_w;
	logic [Q_W-1:0]           q_q;

	assign prod_w = weight * act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.mag_en) begin
			acc_q <= '0;
		end else if (ctl.acc_en && active) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_w[PROD_W-1]}}, prod_w};
		end
	end

	// magnitude and sign of the finished sum
	always_ff @(posedge clk) begin
		if (ctl.mag_en) begin
			neg_q <= active & acc_q[ACC_W-1];
			if (!active) begin
				mag_q <= '0;
			end else if (acc_q[ACC_W-1]) begin
				mag_q <= ~acc_q + ACC_W'(1);
			end else begin
				mag_q <= acc_q;
			end
		end
	end

	// one 40x16 multiplier, upper scale half then lower half
	assign mul_b = ctl.hi_en ? scale[SCALE_W-1:HALF_W] : scale[HALF_W-1:0];
	assign mul_p = PP_W'(mag_q) * PP_W'(mul_b);

	always_ff @(posedge clk) begin
		if (ctl.hi_en) begin
			p_hi_q <= mul_p;
		end
		if (ctl.lo_en) begin
			p_lo_q <= mul_p;
		end
	end

	assign sum_w = {p_hi_q, {HALF_W{1'b0}}} + SUM_W'(p_lo_q) + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (ctl.sum_en) begin
			q_q <= sum_w[SUM_W-1:FRAC_SH];
		end
	end

	// clip to 32 bits and restore the sign
	always_comb begin
		res = q_q[OUT_W-1:0];
		sat = 1'b0;
		if (!neg_q) begin
			if (q_q > POS_LIMIT) begin
				res = OUT_POS_MAX;
				sat = 1'b1;
			end
		end else begin
			if (q_q > NEG_LIMIT) begin
				res = OUT_NEG_MIN;
				sat = 1'b1;
			end else begin
				res = ~q_q[OUT_W-1:0] + OUT_W'(1);
			end
		end
	end

endmodule

### rtl/core/i8gemv_merge.sv
// merge stage: gathers lane results, ors the clip flags, holds the output word
// uses i8gemv_pkg
module i8gemv_merge (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            load,
	input  logic [i8gemv_pkg::LANES-1:0][i8gemv_pkg::OUT_W-1:0] lane_res,
	input  logic [i8gemv_pkg::LANES-1:0]                    lane_sat,
	input  logic                                            out_ready,
	output logic                                            out_valid,
	output logic                                            free,
	output logic [i8gemv_pkg::LANES-1:0][i8gemv_pkg::OUT_W-1:0] res_q,
	output logic                                            sat_q
);
	import i8gemv_pkg::*;

	logic valid_q;

	assign out_valid = valid_q;
	assign free      = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= lane_res;
			sat_q <= |lane_sat;
		end
	end

endmodule

### sim/int8_weight_batched_gemv_unit_test.sv
`timescale 1ns / 1ps
// testbench of int8_weight_batched_gemv_unit: predicts every row result from the accepted words
// and checks each output word in order; depends on rtl/core/i8gemv_pkg.sv and the unit itself

module int8_weight_batched_gemv_unit_test;
	import i8gemv_pkg::*;

	localparam int LONG_WORDS  = 40;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 160;

	typedef struct packed {
		logic [W_W-1:0]                weight;
		logic [LANES-1:0][ACT_W-1:0]   act;
		logic [SCALE_W-1:0]            scale;
		logic                          eor;
	} gemv_word_t;

	typedef struct packed {
		logic [LANES-1:0][OUT_W-1:0] lane;
		logic                        sat;
	} row_result_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	class gemv_row_tracker;
		logic [ACC_W-1:0] acc [LANES];
		logic [BR_W-1:0]  batch;
		row_result_t      expected_rows[$];
		int               mismatches;
		int               rows_checked;

		function new();
			batch = BATCH_RESET;
			for (int i = 0; i < LANES; i++)
				acc[i] = '0;
			mismatches = 0;
			rows_checked = 0;
		endfunction

		// sum times Q8.24 scale, round half away from zero, clip to 32 bits
		function logic [OUT_W-1:0] dequant(logic [ACC_W-1:0] a, logic [SCALE_W-1:0] s,
				output bit clipped);
			logic [ACC_W-1:0] mag;
			logic [SUM_W-1:0] q;
			mag = a[ACC_W-1] ? -a : a;
			q = (SUM_W'(mag) * SUM_W'(s) + ROUND_HALF) >> FRAC_SH;
			clipped = 1'b0;
			if (!a[ACC_W-1]) begin
				if (q > SUM_W'(POS_LIMIT)) begin
					clipped = 1'b1;
					return OUT_POS_MAX;
				end
				return q[OUT_W-1:0];
			end
			if (q > SUM_W'(NEG_LIMIT)) begin
				clipped = 1'b1;
				return OUT_NEG_MIN;
			end
			return -q[OUT_W-1:0];
		endfunction

		function void note_word(gemv_word_t w);
			logic signed [PROD_W-1:0] p;
			row_result_t r;
			bit clipped;
			r = '0;
			for (int i = 0; i < LANES; i++)
				if (i < batch) begin
					p = $signed(w.weight) * $signed(w.act[i]);
					acc[i] = acc[i] + ACC_W'(p);
				end
			if (!w.eor)
				return;
			for (int i = 0; i < LANES; i++) begin
				if (i < batch) begin
					r.lane[i] = dequant(acc[i], w.scale, clipped);
					r.sat = r.sat | clipped;
				end
				acc[i] = '0;
			end
			expected_rows.push_back(r);
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: %s", $time, what);
		endfunction

		function void check_row(row_result_t got);
			row_result_t want;
			if (expected_rows.size() == 0) begin
				flag($sformatf("result word with no row pending, got %h", got));
				return;
			end
			want = expected_rows.pop_front();
			rows_checked++;
			for (int i = 0; i < LANES; i++)
				if (got.lane[i] !== want.lane[i])
					flag($sformatf("out_lane%0d expected %h got %h", i,
						want.lane[i], got.lane[i]));
			if (got.sat !== want.sat)
				flag($sformatf("saturated expected %b got %b", want.sat, got.sat));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [BR_W-1:0]    batch_rows = BATCH_RESET;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [7:0]  weight = '0;
	logic signed [15:0] act_lane0 = '0;
	logic signed [15:0] act_lane1 = '0;
	logic signed [15:0] act_lane2 = '0;
	logic signed [15:0] act_lane3 = '0;
	logic [31:0]        row_scale = '0;
	logic               end_of_row = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] out_lane0;
	logic signed [31:0] out_lane1;
	logic signed [31:0] out_lane2;
	logic signed [31:0] out_lane3;
	logic               saturated;
	row_result_t        seen_row;

	gemv_row_tracker gemv_rows = new();

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_request = 0;
	int words_sent = 0;

	always #5 clk = ~clk;

	int8_weight_batched_gemv_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.batch_rows (batch_rows),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.weight     (weight),
		.act_lane0  (act_lane0),
		.act_lane1  (act_lane1),
		.act_lane2  (act_lane2),
		.act_lane3  (act_lane3),
		.row_scale  (row_scale),
		.end_of_row (end_of_row),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_lane0  (out_lane0),
		.out_lane1  (out_lane1),
		.out_lane2  (out_lane2),
		.out_lane3  (out_lane3),
		.saturated  (saturated)
	);

	assign seen_row = {out_lane3, out_lane2, out_lane1, out_lane0, saturated};

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			gemv_rows.check_row(seen_row);
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin : receiver
		int hold_left;
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic gemv_word_t make_word(logic [7:0] w, logic [15:0] a0, logic [15:0] a1,
			logic [15:0] a2, logic [15:0] a3, logic [31:0] s, logic e);
		gemv_word_t word;
		word.weight = w;
		word.act[0] = a0;
		word.act[1] = a1;
		word.act[2] = a2;
		word.act[3] = a3;
		word.scale = s;
		word.eor = e;
		return word;
	endfunction

	function automatic logic [15:0] pick_act();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(3))
			0: return $urandom;
			1: return ($urandom_range(1) != 0) ? 32'hffff_ffff : 32'h0;
			default: return $urandom_range(32'h0200_0000);
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(gemv_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		weight <= w.weight;
		act_lane0 <= w.act[0];
		act_lane1 <= w.act[1];
		act_lane2 <= w.act[2];
		act_lane3 <= w.act[3];
		row_scale <= w.scale;
		end_of_row <= w.eor;
		do
			@(posedge clk);
		while (!in_ready);
		gemv_rows.note_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_row();
		int len;
		gemv_word_t w;
		len = ($urandom_range(9) == 0) ? $urandom_range(64, 16) : $urandom_range(8, 1);
		for (int k = 0; k < len; k++) begin
			w.weight = 8'($urandom);
			for (int i = 0; i < LANES; i++)
				w.act[i] = pick_act();
			w.eor = (k == len - 1);
			w.scale = w.eor ? pick_scale() : $urandom;
			send_word(w);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (gemv_rows.expected_rows.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_batch(logic [BR_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		batch_rows <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		gemv_rows.batch = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [BR_W-1:0] batch_plan [PHASES];
		idle_mode_t mode;
		int target;
		batch_plan = '{3'd1, 3'd7, 3'd0, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes, rounding ties, exact negative limit, clipping both ways
		send_word(make_word(8'h80, 16'h8000, 16'h7fff, 16'h0000, 16'h0001,
			32'h0100_0000, 1'b1));
		send_word(make_word(8'h7f, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 32'h0, 1'b1));
		send_word(make_word(8'h01, 16'h0001, 16'hffff, 16'h0003, 16'hfffd,
			32'h0080_0000, 1'b1));
		for (int k = 0; k < 8; k++)
			send_word(make_word(8'h40, 16'h8000, 16'h7fff, 16'h4000, 16'hffff,
				32'h8000_0000, k == 7));
		for (int k = 0; k < 3; k++)
			send_word(make_word(8'h80, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
				32'hffff_ffff, 1'b0));
		send_word(make_word(8'h00, 16'h7fff, 16'h8000, 16'hffff, 16'h0000,
			32'hffff_ffff, 1'b1));

		// long row of extreme products
		for (int k = 0; k <= LONG_WORDS; k++)
			send_word(make_word(8'h80, 16'h8000, 16'h8000, 16'h7fff, 16'h0001,
				32'h0000_0100, k == LONG_WORDS));

		for (int ph = 0; ph < PHASES; ph++) begin
			write_batch(batch_plan[ph]);
			mode = idle_mode_t'(ph % 4);
			idle_pct = (mode == IDLE_SENDER) ? 76 : (mode == IDLE_BOTH) ? 6 : 0;
			stall_pct = (mode == IDLE_RECEIVER) ? 76 : (mode == IDLE_BOTH) ? 6 : 0;
			if (ph == 0) begin
				@(posedge clk);
				hold_request = 400;
				@(negedge clk);
			end
			target = words_sent + PHASE_WORDS;
			while (words_sent < target)
				send_random_row();
		end

		drain();
		repeat (20) @(posedge clk);
		$display("sent %0d words: directed extremes, one long row, %0d random phases",
			words_sent, PHASES);
		$display("batch counts 0 to 7 with all idle mixes, %0d row results checked",
			gemv_rows.rows_checked);
		if (gemv_rows.mismatches == 0 && gemv_rows.expected_rows.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
